// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that is checked at every rising clock edge outside reset.
`define CHK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// Max-heap priority queue package
// Key, status and opcode codes plus the controller/datapath command types.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    localparam int KEY_W = 32;

    typedef logic signed [KEY_W-1:0] key_t;

    // Request opcodes.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    // Address selection for the two memory read ports.
    typedef enum logic [1:0] {
        RD_NONE,
        RD_PARENT,
        RD_CHILDREN,
        RD_ROOT_LAST
    } rd_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    start;      // capture the request key, clear the result
        logic    set_status; // overwrite the result status
        status_t status;
        rd_sel_t rd_sel;
        logic    del_load;   // take root as result, last entry as moving key
        logic    wr_key;     // write the moving key at the current position
        logic    move_up;    // parent moves down into the current position
        logic    move_down;  // larger child moves up into the current position
        logic    cnt_inc;
        logic    out_load;   // copy the result into the output register
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic pos_zero;
        logic parent_less;
        logic leaf;
        logic child_wins;
    } dp_sts_t;

endpackage

// ===== rtl/mhpq_if.sv =====
// ----------------------------------------------------------------------------
// Max-heap priority queue channels
// Valid/ready request and result channels with source and sink modports.
// ----------------------------------------------------------------------------
interface mhpq_req_if;
    logic           valid;
    logic           ready;
    logic           opcode;
    mhpq_pkg::key_t value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink (input valid, input opcode, input value, output ready);
endinterface

interface mhpq_rsp_if;
    logic              valid;
    logic              ready;
    mhpq_pkg::key_t    value_res;
    mhpq_pkg::status_t status;

    modport source (output valid, output value_res, output status, input ready);
    modport sink (input valid, input value_res, input status, output ready);
endinterface

// ===== rtl/mhpq_datapath.sv =====
// ----------------------------------------------------------------------------
// Max-heap priority queue datapath
// Heap memory, entry count, moving key, position and result registers.
// ----------------------------------------------------------------------------
module mhpq_datapath #(
    parameter int CAPACITY = 128
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mhpq_pkg::dp_cmd_t   cmd,
    output mhpq_pkg::dp_sts_t   sts,
    input  mhpq_pkg::key_t      req_value,
    output mhpq_pkg::key_t      out_value,
    output mhpq_pkg::status_t   out_status
);
    import mhpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = AW + 2;

    // Heap storage with one write and two read ports.
    key_t          mem [CAPACITY];
    key_t          rd_a_reg;
    key_t          rd_b_reg;
    logic [AW-1:0] addr_a;
    logic [AW-1:0] addr_b;

    logic [CW-1:0] count_reg;
    logic [AW-1:0] pos_reg;
    key_t          key_reg;
    key_t          res_value_reg;
    status_t       res_status_reg;
    key_t          out_value_reg;
    status_t       out_status_reg;

    logic [LW-1:0] lc_idx;
    logic [LW-1:0] rc_idx;
    logic [LW-1:0] count_ext;
    logic [AW-1:0] parent_pos;
    logic          rc_live;
    logic          left_gt;
    logic          right_better;
    key_t          child_data;
    logic [AW-1:0] child_pos;
    logic          mem_we;
    key_t          mem_wdata;

    // Child and parent positions of the current position.
    assign lc_idx     = {1'b0, pos_reg, 1'b1};
    assign rc_idx     = lc_idx + LW'(1);
    assign count_ext  = LW'(count_reg);
    assign parent_pos = (pos_reg - AW'(1)) >> 1;
    assign rc_live    = rc_idx < count_ext;

    // Larger-child choice; the left child wins a tie.
    assign left_gt      = rd_a_reg > key_reg;
    assign right_better = rc_live && (rd_b_reg > (left_gt ? rd_a_reg : key_reg));
    assign child_data   = right_better ? rd_b_reg : rd_a_reg;
    assign child_pos    = right_better ? rc_idx[AW-1:0] : lc_idx[AW-1:0];

    assign sts.full        = count_reg == CW'(CAPACITY);
    assign sts.empty       = count_reg == '0;
    assign sts.pos_zero    = pos_reg == '0;
    assign sts.parent_less = rd_a_reg < key_reg;
    assign sts.leaf        = lc_idx >= count_ext;
    assign sts.child_wins  = left_gt || right_better;

    // Read address selection.
    always_comb
    begin
        addr_a = '0;
        addr_b = '0;
        case (cmd.rd_sel)
            RD_PARENT:
            begin
                addr_a = parent_pos;
            end
            RD_CHILDREN:
            begin
                addr_a = lc_idx[AW-1:0];
                addr_b = rc_idx[AW-1:0];
            end
            RD_ROOT_LAST:
            begin
                addr_a = '0;
                addr_b = AW'(count_reg - CW'(1));
            end
            default:
            begin
                addr_a = '0;
                addr_b = '0;
            end
        endcase
    end

    // Write data: the moving key or the entry that trades places with it.
    assign mem_we    = cmd.wr_key || cmd.move_up || cmd.move_down;
    assign mem_wdata = cmd.wr_key ? key_reg : (cmd.move_up ? rd_a_reg : child_data);

    // Memory ports.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[pos_reg] <= mem_wdata;
        end
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
    end

    // Entry count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.cnt_inc)
        begin
            count_reg <= count_reg + CW'(1);
        end
        else if (cmd.del_load)
        begin
            count_reg <= count_reg - CW'(1);
        end
    end

    // Moving key, position and result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            key_reg        <= req_value;
            pos_reg        <= AW'(count_reg);
            res_value_reg  <= '0;
            res_status_reg <= cmd.set_status ? cmd.status : ST_OK;
        end
        else if (cmd.set_status)
        begin
            res_status_reg <= cmd.status;
        end
        if (cmd.del_load)
        begin
            res_value_reg <= rd_a_reg;
            key_reg       <= rd_b_reg;
            pos_reg       <= '0;
        end
        if (cmd.move_up)
        begin
            pos_reg <= parent_pos;
        end
        if (cmd.move_down)
        begin
            pos_reg <= child_pos;
        end
        if (cmd.out_load)
        begin
            out_value_reg  <= res_value_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;

endmodule

// ===== rtl/mhpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Max-heap priority queue controller
// Sequences insert sift-up and delete sift-down steps and the result handshake.
// ----------------------------------------------------------------------------
module mhpq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_opcode,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    input  mhpq_pkg::dp_sts_t sts,
    output mhpq_pkg::dp_cmd_t cmd
);
    import mhpq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_DEL_RD,
        S_DEL_LOAD,
        S_DN_RD,
        S_DN_CMP,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   out_free;

    assign req_ready = state_reg == S_IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign out_free  = !rsp_valid_reg || rsp_ready;

    // Next state and datapath commands.
    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        cmd            = '0;
        cmd.status     = ST_OK;
        cmd.rd_sel     = RD_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.start = 1'b1;
                    if (req_opcode == OP_INSERT)
                    begin
                        if (sts.full)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_OVERFLOW;
                            state_next     = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_UP_RD;
                        end
                    end
                    else if (sts.empty)
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_UNDERFLOW;
                        state_next     = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_DEL_RD;
                    end
                end
            end
            S_UP_RD:
            begin
                if (sts.pos_zero)
                begin
                    cmd.wr_key  = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_FINISH;
                end
                else
                begin
                    cmd.rd_sel = RD_PARENT;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (sts.parent_less)
                begin
                    cmd.move_up = 1'b1;
                    state_next  = S_UP_RD;
                end
                else
                begin
                    cmd.wr_key  = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_FINISH;
                end
            end
            S_DEL_RD:
            begin
                cmd.rd_sel = RD_ROOT_LAST;
                state_next = S_DEL_LOAD;
            end
            S_DEL_LOAD:
            begin
                cmd.del_load = 1'b1;
                state_next   = S_DN_RD;
            end
            S_DN_RD:
            begin
                if (sts.leaf)
                begin
                    cmd.wr_key = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.rd_sel = RD_CHILDREN;
                    state_next = S_DN_CMP;
                end
            end
            S_DN_CMP:
            begin
                if (sts.child_wins)
                begin
                    cmd.move_down = 1'b1;
                    state_next    = S_DN_RD;
                end
                else
                begin
                    cmd.wr_key = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// ===== rtl/max_heap_priority_queue.sv =====
// ----------------------------------------------------------------------------
// Max-heap priority queue
// Binary max-heap of signed 32-bit keys with insert and delete-max requests.
// ----------------------------------------------------------------------------
// Usage:
// A request on req carries an opcode (insert or delete-max) and a key. Each
// request gives exactly one result on rsp: the removed maximum with status ok
// on a delete, zero with status ok on an insert, zero with overflow for an
// insert into a full heap, or zero with underflow for a delete from an empty
// heap. Requests are taken one at a time; req.ready is high while the block
// is idle. Each heap level takes a memory read, then a compare and write.
// A delete first reads the root and the last entry and loads them, and a
// rejected request goes straight to its result. After each request the
// block returns to idle before the next request is taken. The result sits
// in an output register, so the next request is accepted and worked on while
// rsp is stalled; it then waits for that register to free. Reset empties the
// heap and drops any pending result.
// ----------------------------------------------------------------------------
module max_heap_priority_queue #(
    parameter int CAPACITY = 128
) (
    input  logic       clk,
    input  logic       rst_n,
    mhpq_req_if.sink   req,
    mhpq_rsp_if.source rsp
);
    import mhpq_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    mhpq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_opcode (req.opcode),
        .req_ready  (req.ready),
        .rsp_valid  (rsp.valid),
        .rsp_ready  (rsp.ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    mhpq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .req_value  (req.value),
        .out_value  (rsp.value_res),
        .out_status (rsp.status)
    );

endmodule

// ===== rtl/mhpq_checker.sv =====
// ----------------------------------------------------------------------------
// Max-heap priority queue checker
// Port-level assertions on request/result ordering and result contents.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mhpq_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input mhpq_pkg::key_t    rsp_value_res,
    input mhpq_pkg::status_t rsp_status
);
    import mhpq_pkg::*;

    logic       req_fire;
    logic       rsp_fire;
    logic [1:0] pending_reg;

    assign req_fire = req_valid && req_ready;
    assign rsp_fire = rsp_valid && rsp_ready;

    // Requests accepted whose result has not yet been taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (req_fire && !rsp_fire)
        begin
            pending_reg <= pending_reg + 2'd1;
        end
        else if (rsp_fire && !req_fire)
        begin
            pending_reg <= pending_reg - 2'd1;
        end
    end

    `CHK_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value_res) && $stable(rsp_status), "stalled result changed")
    `CHK_ALWAYS(a_rsp_has_req, !rsp_valid || pending_reg != 2'd0, "result without a request")
    `CHK_ALWAYS(a_pending_bound, pending_reg != 2'd3, "more than two requests outstanding")
    `CHK_ALWAYS(a_fail_zero, !rsp_valid || rsp_status == ST_OK || rsp_value_res == '0, "failed request returned a value")

endmodule

bind max_heap_priority_queue mhpq_checker u_mhpq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_value_res (rsp.value_res),
    .rsp_status    (rsp.status)
);
